### rtl/core/rpn_pkg.sv
package rpn_pkg;

  // Channel widths
  localparam int MODE_W     = 3;
  localparam int NUM_W      = 48;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 3;
  localparam int IN_TDATA_W = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int PROD_W     = 64;

  // Token kinds
  localparam logic [MODE_W-1:0] MODE_NUM    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REM    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNSUPP = 3'd6;
  localparam logic [MODE_W-1:0] MODE_END    = 3'd7;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DIVZERO  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NUMBIG   = 3'd2;
  localparam logic [STAT_W-1:0] ST_RESBIG   = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNSUPP   = 3'd4;
  localparam logic [STAT_W-1:0] ST_SYNTAX   = 3'd5;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              capture;   // take the input request
    logic              push;      // push the captured number
    logic              rd_issue;  // read the left operand from the stack
    logic              set_err;   // latch err_code as the held error
    logic [STAT_W-1:0] err_code;
    logic              exec;      // add, subtract or multiply into the result register
    logic              div_start; // launch the divider
    logic              div_load;  // take the signed quotient or remainder
    logic              commit;    // pop one and replace the top with the result
    logic              ld_out;    // load the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              err_held;
    logic              cnt_lt2;
    logic              full;
    logic              num_ok;
    logic              top_zero;
    logic              div_done;
    logic              res_fits;
    logic              out_free;
  } sts_t;

endpackage

### rtl/core/rpn_div.sv
module rpn_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  import rpn_pkg::*;

  localparam int DW = VAL_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    q_r, r_r, d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  // One restoring step: shift in the next dividend bit and try a subtract
  assign trial = {r_r, q_r[DW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in from the right, remainder builds up
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        r_r <= diff[DW-1:0];
        q_r <= {q_r[DW-2:0], 1'b1};
      end else begin
        r_r <= trial[DW-1:0];
        q_r <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

  // A finished division reports once per start
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

endmodule

### rtl/core/rpn_dp.sv
module rpn_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rpn_pkg::cmd_t                   cmd,
  output rpn_pkg::sts_t                   sts,
  input  logic [rpn_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [rpn_pkg::MODE_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rpn_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import rpn_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int PAD_W = OUT_TDATA_W - STAT_W - VAL_W;

  logic [VAL_W-1:0]  mem [STACK_DEPTH];
  logic [MODE_W-1:0] mode_r;
  logic [NUM_W-1:0]  num_r;
  logic [CW-1:0]     count_r;
  logic [STAT_W-1:0] err_r;
  logic [VAL_W-1:0]  top_r;
  logic [VAL_W-1:0]  rd_r;
  logic [PROD_W-1:0] res_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_stat_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_last_r;

  logic [CW-1:0]     cnt_m2;
  logic [AW-1:0]     idx2;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic signed [VAL_W-1:0]  l_s, r_s;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0] l64, r64;
  logic [VAL_W-1:0]  mag_l, mag_r, div_quot, div_rem;
  logic              div_done;
  logic [VAL_W:0]    q_sg, rm_sg;
  logic              is_end;
  logic [STAT_W-1:0] stat_o;
  logic [VAL_W-1:0]  val_o;

  assign cnt_m2  = count_r - CW'(2);
  assign idx2    = cnt_m2[AW-1:0];
  assign wr_addr = cmd.push ? count_r[AW-1:0] : idx2;
  assign wr_data = cmd.push ? num_r[VAL_W-1:0] : res_r[VAL_W-1:0];

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push || cmd.commit) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_r <= mem[idx2];
    end
  end

  // Hold the captured request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_tuser;
      num_r  <= in_tdata[NUM_W-1:0];
    end
  end

  // Arithmetic: left operand from memory, right operand is the cached top
  assign l_s  = rd_r;
  assign r_s  = top_r;
  assign prod = PROD_W'(l_s) * PROD_W'(r_s);
  assign l64  = {{(PROD_W-VAL_W){rd_r[VAL_W-1]}}, rd_r};
  assign r64  = {{(PROD_W-VAL_W){top_r[VAL_W-1]}}, top_r};
  assign mag_l = rd_r[VAL_W-1]  ? (VAL_W'(0) - rd_r)  : rd_r;
  assign mag_r = top_r[VAL_W-1] ? (VAL_W'(0) - top_r) : top_r;

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_l),
    .divisor  (mag_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Truncating division: quotient sign from both operands, remainder from the left
  assign q_sg  = (rd_r[VAL_W-1] ^ top_r[VAL_W-1]) ? ((VAL_W+1)'(0) - {1'b0, div_quot})
                                                  : {1'b0, div_quot};
  assign rm_sg = rd_r[VAL_W-1] ? ((VAL_W+1)'(0) - {1'b0, div_rem}) : {1'b0, div_rem};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (mode_r)
        MODE_ADD: res_r <= l64 + r64;
        MODE_SUB: res_r <= l64 - r64;
        default:  res_r <= prod;
      endcase
    end else if (cmd.div_load) begin
      if (mode_r == MODE_DIV) begin
        res_r <= {{(PROD_W-VAL_W-1){q_sg[VAL_W]}}, q_sg};
      end else begin
        res_r <= {{(PROD_W-VAL_W-1){rm_sg[VAL_W]}}, rm_sg};
      end
    end
  end

  // Result for the output register
  assign is_end = (mode_r == MODE_END);
  always_comb begin
    if (is_end) begin
      if (err_r != ST_OK) begin
        stat_o = err_r;
        val_o  = '0;
      end else if (count_r != CW'(1)) begin
        stat_o = ST_SYNTAX;
        val_o  = '0;
      end else begin
        stat_o = ST_OK;
        val_o  = top_r;
      end
    end else begin
      stat_o = err_r;
      val_o  = (count_r == '0) ? '0 : top_r;
    end
  end

  // Stack pointer, cached top and held error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= ST_OK;
    end else begin
      if (cmd.push) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.commit) begin
        count_r <= count_r - 1'b1;
      end else if (cmd.ld_out && is_end) begin
        count_r <= '0;
      end
      if (cmd.set_err) begin
        err_r <= cmd.err_code;
      end else if (cmd.ld_out && is_end) begin
        err_r <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_r <= num_r[VAL_W-1:0];
    end else if (cmd.commit) begin
      top_r <= res_r[VAL_W-1:0];
    end
  end

  // Output register: frees when the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_stat_r <= stat_o;
      out_val_r  <= val_o;
      out_last_r <= is_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_val_r, out_stat_r};
  assign out_tlast  = out_last_r;

  // Status toward the controller
  assign sts.mode     = mode_r;
  assign sts.err_held = (err_r != ST_OK);
  assign sts.cnt_lt2  = (count_r < CW'(2));
  assign sts.full     = (count_r >= CW'(STACK_DEPTH));
  assign sts.num_ok   = (&num_r[NUM_W-1:VAL_W-1]) || (~|num_r[NUM_W-1:VAL_W-1]);
  assign sts.top_zero = (top_r == '0);
  assign sts.div_done = div_done;
  assign sts.res_fits = (&res_r[PROD_W-1:VAL_W-1]) || (~|res_r[PROD_W-1:VAL_W-1]);
  assign sts.out_free = !out_valid_r || out_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_out && is_end) |=> (count_r == '0) && (err_r == ST_OK))
    else $error("end of expression did not clear the stack");

endmodule

### rtl/core/rpn_ctrl.sv
module rpn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rpn_pkg::sts_t sts,
  output rpn_pkg::cmd_t cmd
);
  import rpn_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DIVW   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Sequence one token through decode, operand read, execute and output
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        if (sts.mode == MODE_END || sts.err_held) begin
          state_nxt = S_OUT;
        end else if (sts.mode == MODE_UNSUPP) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_UNSUPP;
        end else if (sts.mode == MODE_NUM) begin
          if (!sts.num_ok) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_NUMBIG;
          end else if (sts.full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_OVERFLOW;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (sts.cnt_lt2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_SYNTAX;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        if (sts.mode == MODE_DIV || sts.mode == MODE_REM) begin
          if (sts.top_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_DIVZERO;
            state_nxt    = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIVW;
          end
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_COMMIT;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.res_fits) begin
          cmd.commit = 1'b1;
        end else begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_RESBIG;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> sts.out_free)
    else $error("output register overwritten while occupied");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full && sts.num_ok)
    else $error("push onto a full stack or of an out-of-range number");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.top_zero)
    else $error("divider started with a zero divisor");

endmodule

### rtl/core/rpn_stack_evaluator.sv
// Reverse Polish evaluator over pre-classified tokens.
// Input channel (in_*): one request per token. in_tuser carries the token kind
// (number, add, subtract, multiply, divide, remainder, unsupported, end);
// in_tdata carries the 48-bit signed parsed number, used for numbers only.
// Output channel (out_*): exactly one result per token, in order. out_tdata
// holds the status code and the 32-bit top of stack (or the final answer);
// out_tlast marks the result of an end token, which closes the expression.
// out_tvalid rises when the result is loaded into the output register. Numbers,
// unsupported, end and tokens under a held error go from decode straight to
// output; add, subtract and multiply pass decode, read, commit and output;
// divide and remainder also wait on the radix-2 divider, which produces one
// quotient bit per cycle. One token is in work at a time, so the block is ready
// for the next token only after the previous result is loaded into the output register.
// The output register decouples the two sides: a stalled receiver holds the
// current result, and the block still accepts and works the next token, then
// waits with it until the output register frees.
// Reset empties the stack and clears the held error; no clearing pass runs.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rpn_pkg::IN_TDATA_W-1:0]  in_tdata,   // [47:0] number_value
  input  logic [rpn_pkg::MODE_W-1:0]      in_tuser,   // [2:0] mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rpn_pkg::OUT_TDATA_W-1:0] out_tdata,  // [2:0] status, [34:3] value, zero pad
  output logic                            out_tlast   // final_res
);
  import rpn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
